@@ hdl/poisson_disc_accept_insert_defines.svh @@
// assertion macros for the poisson disc accept/insert block
// included by files that carry concurrent assertions; no other dependencies
`ifndef POISSON_DISC_ACCEPT_INSERT_DEFINES_SVH
`define POISSON_DISC_ACCEPT_INSERT_DEFINES_SVH
`ifndef SYNTHESIS
`define PDAI_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PDAI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PDAI_ASSERT(lbl, clk, rst, prop, msg)
`define PDAI_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ hdl/pdai_pkg.sv @@
// shared constants, payload types and codes for the poisson disc accept/insert block
// no dependencies
`timescale 1ns / 1ps

package pdai_pkg;

  localparam int GRID_DIM     = 64;
  localparam int MAX_POINTS   = 4096;
  localparam int SEARCH_REACH = 2;

  localparam int COORD_W    = 16;
  localparam int LIM_W      = 2 * COORD_W;
  localparam int DIVD_W     = COORD_W + 1;
  localparam int CELL_W     = $clog2(GRID_DIM);
  localparam int QUOT_W     = CELL_W + 1;
  localparam int SPAN_W     = CELL_W + 2;
  localparam int PROD_W     = CELL_W + QUOT_W;
  localparam int GRID_CELLS = GRID_DIM * GRID_DIM;
  localparam int GRID_AW    = $clog2(GRID_CELLS);
  localparam int PT_AW      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int IDX_W      = 12;
  localparam int CFG_AW     = 2;

  localparam logic [COORD_W-1:0] CELL_SIZE_RST     = 16'd256;
  localparam logic [COORD_W-1:0] MIN_DISTANCE_RST  = 16'd362;
  localparam logic [COORD_W-1:0] REGION_WIDTH_RST  = 16'd16384;
  localparam logic [COORD_W-1:0] REGION_HEIGHT_RST = 16'd16384;

  typedef enum logic [1:0] {
    ST_ACCEPT  = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_CLOSE   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_CELL_SIZE     = 2'd0,
    REG_MIN_DISTANCE  = 2'd1,
    REG_REGION_WIDTH  = 2'd2,
    REG_REGION_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_W-1:0] cand_x;
    logic [COORD_W-1:0] cand_y;
  } cand_t;

  typedef struct packed {
    status_t            status;
    logic [IDX_W-1:0]   point_index;
  } res_t;

  typedef struct packed {
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } point_t;

  typedef struct packed {
    logic               en;
    logic [GRID_AW-1:0] addr;
    logic [CNT_W-1:0]   tag;
  } grid_wr_t;

  typedef struct packed {
    logic             en;
    logic [PT_AW-1:0] addr;
    point_t           data;
  } store_wr_t;

endpackage

@@ hdl/pdai_div.sv @@
// iterative restoring divider with a quotient saturated to all ones of QUOT_W bits
// depends on pdai_pkg
`timescale 1ns / 1ps

module pdai_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pdai_pkg::DIVD_W-1:0]   dividend,
  input  logic [pdai_pkg::COORD_W-1:0]  divisor,
  output logic                          done,
  output logic [pdai_pkg::QUOT_W-1:0]   quot
);

  localparam int QW    = pdai_pkg::QUOT_W;
  localparam int DW    = pdai_pkg::DIVD_W;
  localparam int SH_W  = pdai_pkg::COORD_W + pdai_pkg::QUOT_W;
  localparam int STP_W = $clog2(QW + 1);

  logic             busy;
  logic             first;
  logic             sat;
  logic [DW-1:0]    rem;
  logic [SH_W-1:0]  dsh;
  logic [STP_W-1:0] steps;
  logic [SH_W-1:0]  rem_ext;
  logic             ge;

  assign rem_ext = SH_W'(rem);
  assign ge      = rem_ext >= dsh;

  // done pulses once the saturation check and all QUOT_W quotient steps are through
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      first <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        first <= 1'b1;
      end else if (busy) begin
        if (first) begin
          first <= 1'b0;
        end else if (steps == STP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // saturation check first, then one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= dividend;
      dsh   <= {divisor, {QW{1'b0}}};
      quot  <= '0;
      sat   <= 1'b0;
      steps <= STP_W'(QW);
    end else if (busy) begin
      if (first) begin
        if (ge) begin
          quot <= '1;
        end
        sat <= ge;
        dsh <= dsh >> 1;
      end else begin
        if (ge) begin
          rem <= DW'(rem_ext - dsh);
        end
        if (!sat) begin
          quot <= {quot[QW-2:0], ge};
        end
        dsh   <= dsh >> 1;
        steps <= steps - STP_W'(1);
      end
    end
  end

endmodule

@@ hdl/pdai_grid.sv @@
// background grid memory: cell tags with a clearing sweep after reset
// depends on pdai_pkg
`timescale 1ns / 1ps

module pdai_grid (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [pdai_pkg::GRID_AW-1:0]  rd_addr,
  output logic [pdai_pkg::CNT_W-1:0]    rd_data,
  input  pdai_pkg::grid_wr_t            wr,
  output logic                          clearing
);

  localparam int AW = pdai_pkg::GRID_AW;

  logic [pdai_pkg::CNT_W-1:0] mem [pdai_pkg::GRID_CELLS];
  logic [AW-1:0]              sweep;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      sweep    <= '0;
    end else if (clearing) begin
      sweep <= sweep + AW'(1);
      if (sweep == AW'(pdai_pkg::GRID_CELLS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[sweep] <= '0;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.tag;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hdl/pdai_store.sv @@
// point store memory: packed (y, x) per accepted point, registered read
// depends on pdai_pkg
`timescale 1ns / 1ps

module pdai_store (
  input  logic                        clk,
  input  logic [pdai_pkg::PT_AW-1:0]  rd_addr,
  output pdai_pkg::point_t            rd_data,
  input  pdai_pkg::store_wr_t         wr
);

  pdai_pkg::point_t mem [pdai_pkg::MAX_POINTS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hdl/poisson_disc_accept_insert.sv @@
// top level of the poisson disc accept/insert block: control, scan pipeline, registers
// depends on pdai_pkg, pdai_div, pdai_grid, pdai_store and the assertion macro header
//
//   beat      direction  handshake             payload
//   cand      in         cand_valid/cand_stall cand_x, cand_y
//   res       out        res_valid/res_stall   status, point_index
//   cfg       in         cfg_valid/cfg_ready   cfg_index, cfg_data
//
// one candidate at a time; outside region or store full goes from S_CHECK straight to S_DONE
// otherwise the result waits on two saturating divide rounds (extents, then the cell), the
// one-cell-per-cycle grid read port and the pipeline drain
// after reset the grid is swept clear over all GRID_DIM*GRID_DIM cells; cand_stall stays high
// the result register frees the input side; a stalled result holds only the next write-back
`timescale 1ns / 1ps
`include "poisson_disc_accept_insert_defines.svh"

module poisson_disc_accept_insert (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cand_valid,
  output logic                          cand_stall,
  input  pdai_pkg::cand_t               cand,
  output logic                          res_valid,
  input  logic                          res_stall,
  output pdai_pkg::res_t                res,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pdai_pkg::CFG_AW-1:0]   cfg_index,
  input  logic [pdai_pkg::COORD_W-1:0]  cfg_data
);

  localparam int CW  = pdai_pkg::COORD_W;
  localparam int QW  = pdai_pkg::QUOT_W;
  localparam int EW  = pdai_pkg::CELL_W;
  localparam int SW  = pdai_pkg::SPAN_W;
  localparam int PW  = pdai_pkg::PROD_W;
  localparam int NW  = pdai_pkg::CNT_W;
  localparam int DW  = pdai_pkg::DIVD_W;
  localparam int LW  = pdai_pkg::LIM_W;
  localparam int GAW = pdai_pkg::GRID_AW;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_CHECK = 8'b0000_0100,
    S_EXT   = 8'b0000_1000,
    S_CELL  = 8'b0001_0000,
    S_SETUP = 8'b0010_0000,
    S_SCAN  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t                 state;
  logic [CW-1:0]          cell_size;
  logic [CW-1:0]          min_distance;
  logic [CW-1:0]          region_width;
  logic [CW-1:0]          region_height;
  logic [NW-1:0]          count;
  pdai_pkg::cand_t        cand_q;
  pdai_pkg::status_t      status_q;
  pdai_pkg::status_t      final_status;
  logic [LW-1:0]          limit;
  logic [QW-1:0]          cols;
  logic [QW-1:0]          rows;
  logic [EW-1:0]          cx;
  logic [EW-1:0]          cy;
  logic [EW-1:0]          x0;
  logic [EW-1:0]          x1;
  logic [EW-1:0]          y1;
  logic [EW-1:0]          x0_c;
  logic [EW-1:0]          x1_c;
  logic [EW-1:0]          y0_c;
  logic [EW-1:0]          y1_c;
  logic [EW-1:0]          gx;
  logic [EW-1:0]          gy;
  logic [GAW-1:0]         ins_addr;
  logic [GAW-1:0]         scan_addr;
  logic                   run;
  logic                   v1;
  logic                   v2;
  logic                   v3;
  logic                   close;
  logic [LW-1:0]          sqx;
  logic [LW-1:0]          sqy;
  logic signed [CW:0]     dx;
  logic signed [CW:0]     dy;
  logic signed [2*CW+1:0] sqx_full;
  logic signed [2*CW+1:0] sqy_full;
  logic [LW:0]            d2;
  logic [NW-1:0]          tag;
  logic [NW-1:0]          grid_rd_data;
  logic                   hit;
  logic                   outside;
  logic                   full;
  logic                   res_free;
  logic                   commit;
  logic [CW-1:0]          cs_eff;
  logic                   div_start;
  logic [DW-1:0]          div_a_in;
  logic [DW-1:0]          div_b_in;
  logic                   div_a_done;
  logic                   div_b_done;
  logic [QW-1:0]          div_a_q;
  logic [QW-1:0]          div_b_q;
  logic                   grid_clearing;
  pdai_pkg::point_t       store_rd;
  pdai_pkg::grid_wr_t     grid_wr;
  pdai_pkg::store_wr_t    store_wr;

  function automatic logic [QW-1:0] sat_extent(input logic [QW-1:0] q);
    logic [QW-1:0] r;
    r = q;
    if (q == '0) begin
      r = QW'(1);
    end else if (q > QW'(pdai_pkg::GRID_DIM)) begin
      r = QW'(pdai_pkg::GRID_DIM);
    end
    return r;
  endfunction

  function automatic logic [EW-1:0] clamp_cell(input logic [QW-1:0] q, input logic [QW-1:0] n);
    logic [QW-1:0] r;
    r = (q >= n) ? n - QW'(1) : q;
    return EW'(r);
  endfunction

  function automatic logic [EW-1:0] win_lo(input logic [EW-1:0] c);
    return (c >= EW'(pdai_pkg::SEARCH_REACH)) ? c - EW'(pdai_pkg::SEARCH_REACH) : '0;
  endfunction

  function automatic logic [EW-1:0] win_hi(input logic [EW-1:0] c, input logic [QW-1:0] n);
    logic [SW-1:0] top;
    logic [SW-1:0] last;
    top  = SW'(c) + SW'(pdai_pkg::SEARCH_REACH);
    last = SW'(n) - SW'(1);
    return (top > last) ? EW'(last) : EW'(top);
  endfunction

  assign cfg_ready  = 1'b1;
  assign cand_stall = (state != S_IDLE);
  assign cs_eff     = (cell_size == '0) ? CW'(1) : cell_size;
  assign outside    = (cand_q.cand_x >= region_width) || (cand_q.cand_y >= region_height);
  assign full       = count >= NW'(pdai_pkg::MAX_POINTS);
  assign res_free   = !res_valid || !res_stall;

  assign final_status = (status_q == pdai_pkg::ST_ACCEPT && close) ? pdai_pkg::ST_CLOSE
                                                                   : status_q;
  assign commit = (state == S_DONE) && res_free && (final_status == pdai_pkg::ST_ACCEPT);

  // dividers: extents first, then the candidate's cell
  assign div_start = ((state == S_CHECK) && !outside && !full)
                  || ((state == S_EXT) && div_a_done && div_b_done);
  assign div_a_in  = (state == S_CHECK) ? DW'(region_width) + DW'(cs_eff) - DW'(1)
                                        : DW'(cand_q.cand_x);
  assign div_b_in  = (state == S_CHECK) ? DW'(region_height) + DW'(cs_eff) - DW'(1)
                                        : DW'(cand_q.cand_y);

  pdai_div u_div_a (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a_in),
    .divisor  (cs_eff),
    .done     (div_a_done),
    .quot     (div_a_q)
  );

  pdai_div u_div_b (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_b_in),
    .divisor  (cs_eff),
    .done     (div_b_done),
    .quot     (div_b_q)
  );

  // window bounds
  assign x0_c = win_lo(cx);
  assign y0_c = win_lo(cy);
  assign x1_c = win_hi(cx, cols);
  assign y1_c = win_hi(cy, rows);

  assign scan_addr = GAW'(PW'(gy) * PW'(cols) + PW'(gx));

  // stage 1: grid tag back
  assign tag = grid_rd_data;
  assign hit = (tag != '0) && (tag <= count);

  pdai_grid u_grid (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (scan_addr),
    .rd_data  (grid_rd_data),
    .wr       (grid_wr),
    .clearing (grid_clearing)
  );

  assign grid_wr.en   = commit;
  assign grid_wr.addr = ins_addr;
  assign grid_wr.tag  = count + NW'(1);

  pdai_store u_store (
    .clk     (clk),
    .rd_addr (pdai_pkg::PT_AW'(tag - NW'(1))),
    .rd_data (store_rd),
    .wr      (store_wr)
  );

  assign store_wr.en     = commit;
  assign store_wr.addr   = pdai_pkg::PT_AW'(count);
  assign store_wr.data.x = cand_q.cand_x;
  assign store_wr.data.y = cand_q.cand_y;

  // stage 2: squared offsets
  assign dx       = $signed({1'b0, cand_q.cand_x}) - $signed({1'b0, store_rd.x});
  assign dy       = $signed({1'b0, cand_q.cand_y}) - $signed({1'b0, store_rd.y});
  assign sqx_full = dx * dx;
  assign sqy_full = dy * dy;

  // stage 3: distance test
  assign d2 = {1'b0, sqx} + {1'b0, sqy};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      count         <= '0;
      res_valid     <= 1'b0;
      run           <= 1'b0;
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      cell_size     <= pdai_pkg::CELL_SIZE_RST;
      min_distance  <= pdai_pkg::MIN_DISTANCE_RST;
      region_width  <= pdai_pkg::REGION_WIDTH_RST;
      region_height <= pdai_pkg::REGION_HEIGHT_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pdai_pkg::REG_CELL_SIZE:     cell_size     <= cfg_data;
          pdai_pkg::REG_MIN_DISTANCE:  min_distance  <= cfg_data;
          pdai_pkg::REG_REGION_WIDTH:  region_width  <= cfg_data;
          pdai_pkg::REG_REGION_HEIGHT: region_height <= cfg_data;
          default: ;
        endcase
      end
      v1 <= run;
      v2 <= v1 && hit;
      v3 <= v2;
      if ((state == S_DONE) && res_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (!grid_clearing) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cand_valid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= (outside || full) ? S_DONE : S_EXT;
        end
        S_EXT: begin
          if (div_a_done && div_b_done) begin
            state <= S_CELL;
          end
        end
        S_CELL: begin
          if (div_a_done && div_b_done) begin
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          run   <= 1'b1;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (run) begin
            if (gx == x1 && gy == y1) begin
              run <= 1'b0;
            end
          end else if (!v1 && !v2 && !v3) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_free) begin
            state <= S_IDLE;
            if (commit) begin
              count <= count + NW'(1);
            end
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    sqx <= sqx_full[LW-1:0];
    sqy <= sqy_full[LW-1:0];
    if (v3 && (d2 < {1'b0, limit})) begin
      close <= 1'b1;
    end
    case (state)
      S_IDLE: begin
        if (cand_valid) begin
          cand_q <= cand;
        end
      end
      S_CHECK: begin
        limit <= LW'(min_distance) * LW'(min_distance);
        if (outside) begin
          status_q <= pdai_pkg::ST_OUTSIDE;
        end else if (full) begin
          status_q <= pdai_pkg::ST_FULL;
        end else begin
          status_q <= pdai_pkg::ST_ACCEPT;
        end
      end
      S_EXT: begin
        if (div_a_done && div_b_done) begin
          cols <= sat_extent(div_a_q);
          rows <= sat_extent(div_b_q);
        end
      end
      S_CELL: begin
        if (div_a_done && div_b_done) begin
          cx <= clamp_cell(div_a_q, cols);
          cy <= clamp_cell(div_b_q, rows);
        end
      end
      S_SETUP: begin
        x0       <= x0_c;
        x1       <= x1_c;
        y1       <= y1_c;
        gx       <= x0_c;
        gy       <= y0_c;
        close    <= 1'b0;
        ins_addr <= GAW'(PW'(cy) * PW'(cols) + PW'(cx));
      end
      S_SCAN: begin
        if (run) begin
          if (gx == x1) begin
            gx <= x0;
            gy <= gy + EW'(1);
          end else begin
            gx <= gx + EW'(1);
          end
        end
      end
      S_DONE: begin
        if (res_free) begin
          res.status      <= final_status;
          res.point_index <= commit ? pdai_pkg::IDX_W'(count) : '0;
        end
      end
      default: ;
    endcase
  end

  `PDAI_ASSERT_ALWAYS(a_reset_sweep, clk,
    rst |=> (state == S_CLEAR) && grid_clearing, "grid sweep must follow reset")
  `PDAI_ASSERT(a_count_bound, clk, rst,
    count <= NW'(pdai_pkg::MAX_POINTS), "point count beyond store depth")
  `PDAI_ASSERT(a_count_commit, clk, rst,
    (!$past(rst) && count != $past(count)) |->
    (res_valid && res.status == pdai_pkg::ST_ACCEPT),
    "point count moved without an accepted result")
  `PDAI_ASSERT(a_pipe_idle, clk, rst,
    (state != S_SCAN) |-> !(v1 || v2 || v3), "scan pipeline busy outside scan")
  `PDAI_ASSERT(a_index_zero, clk, rst,
    (res_valid && res.status != pdai_pkg::ST_ACCEPT) |-> (res.point_index == '0),
    "rejected beat carries an index")

endmodule

@@ tb/sv/poisson_disc_accept_insert_chk.sv @@
// checker for the poisson disc accept/insert block: watches the cand, res and cfg beats,
// keeps its own copy of grid, point store and registers, and compares every result beat
// depends on pdai_pkg only
`timescale 1ns / 1ps

module poisson_disc_accept_insert_chk (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cand_valid,
  input  logic                          cand_stall,
  input  pdai_pkg::cand_t               cand,
  input  logic                          res_valid,
  input  logic                          res_stall,
  input  pdai_pkg::res_t                res,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [pdai_pkg::CFG_AW-1:0]   cfg_index,
  input  logic [pdai_pkg::COORD_W-1:0]  cfg_data,
  input  logic                          done,
  output int                            fail_count,
  output int                            pending,
  output int                            n_accept,
  output int                            n_outside,
  output int                            n_close,
  output int                            n_full
);

  logic [pdai_pkg::CNT_W-1:0]   cell_grid [pdai_pkg::GRID_CELLS];
  pdai_pkg::point_t             point_store [pdai_pkg::MAX_POINTS];
  int unsigned                  point_count;
  logic [pdai_pkg::COORD_W-1:0] cell_size;
  logic [pdai_pkg::COORD_W-1:0] min_distance;
  logic [pdai_pkg::COORD_W-1:0] region_width;
  logic [pdai_pkg::COORD_W-1:0] region_height;
  pdai_pkg::res_t               due_verdicts [$];
  pdai_pkg::res_t               want;
  int                           errors = 0;
  int                           tally [4] = '{default: 0};
  bit                           done_seen = 1'b0;

  task automatic report_err(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic int unsigned span_cells(input int unsigned extent, input int unsigned cs);
    int unsigned n;
    n = (extent + cs - 1) / cs;
    if (n < 1) n = 1;
    if (n > pdai_pkg::GRID_DIM) n = pdai_pkg::GRID_DIM;
    return n;
  endfunction

  function automatic pdai_pkg::res_t judge_cand(input logic [pdai_pkg::COORD_W-1:0] px,
                                                input logic [pdai_pkg::COORD_W-1:0] py);
    pdai_pkg::res_t   r;
    int unsigned      cs, cols, rows, cx, cy, x0, y0, x1, y1, tag;
    longint unsigned  lim, d2;
    longint           dx, dy;
    bit               near;
    pdai_pkg::point_t p;
    r.status = pdai_pkg::ST_ACCEPT;
    r.point_index = '0;
    near = 1'b0;
    if (px >= region_width || py >= region_height) begin
      r.status = pdai_pkg::ST_OUTSIDE;
      return r;
    end
    if (point_count >= pdai_pkg::MAX_POINTS) begin
      r.status = pdai_pkg::ST_FULL;
      return r;
    end
    cs = (cell_size == 0) ? 1 : cell_size;
    cols = span_cells(region_width, cs);
    rows = span_cells(region_height, cs);
    cx = px / cs;
    cy = py / cs;
    if (cx >= cols) cx = cols - 1;
    if (cy >= rows) cy = rows - 1;
    x0 = (cx >= pdai_pkg::SEARCH_REACH) ? cx - pdai_pkg::SEARCH_REACH : 0;
    y0 = (cy >= pdai_pkg::SEARCH_REACH) ? cy - pdai_pkg::SEARCH_REACH : 0;
    x1 = (cx + pdai_pkg::SEARCH_REACH > cols - 1) ? cols - 1 : cx + pdai_pkg::SEARCH_REACH;
    y1 = (cy + pdai_pkg::SEARCH_REACH > rows - 1) ? rows - 1 : cy + pdai_pkg::SEARCH_REACH;
    lim = longint'(min_distance) * longint'(min_distance);
    for (int unsigned gy = y0; gy <= y1; gy++) begin
      for (int unsigned gx = x0; gx <= x1; gx++) begin
        tag = cell_grid[gy * cols + gx];
        // empty or stale entries do not count
        if (tag != 0 && tag - 1 < point_count) begin
          p = point_store[tag - 1];
          dx = longint'(px) - longint'(p.x);
          dy = longint'(py) - longint'(p.y);
          d2 = dx * dx + dy * dy;
          if (d2 < lim) near = 1'b1;
        end
      end
    end
    if (near) begin
      r.status = pdai_pkg::ST_CLOSE;
      return r;
    end
    p.x = px;
    p.y = py;
    point_store[point_count] = p;
    cell_grid[cy * cols + cx] = pdai_pkg::CNT_W'(point_count + 1);
    r.point_index = pdai_pkg::IDX_W'(point_count);
    point_count++;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pdai_pkg::GRID_CELLS; i++) cell_grid[i] = '0;
      point_count = 0;
      cell_size = pdai_pkg::CELL_SIZE_RST;
      min_distance = pdai_pkg::MIN_DISTANCE_RST;
      region_width = pdai_pkg::REGION_WIDTH_RST;
      region_height = pdai_pkg::REGION_HEIGHT_RST;
      due_verdicts.delete();
    end else begin
      if (res_valid && !res_stall) begin
        if (due_verdicts.size() == 0) begin
          report_err($sformatf("res beat status %0d index %0d with nothing expected",
                               res.status, res.point_index));
        end else begin
          want = due_verdicts.pop_front();
          if (res.status !== want.status)
            report_err($sformatf("status %0d, expected %0d", res.status, want.status));
          if (res.point_index !== want.point_index)
            report_err($sformatf("point_index %0d, expected %0d",
                                 res.point_index, want.point_index));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (pdai_pkg::cfg_reg_t'(cfg_index))
          pdai_pkg::REG_CELL_SIZE:     cell_size = cfg_data;
          pdai_pkg::REG_MIN_DISTANCE:  min_distance = cfg_data;
          pdai_pkg::REG_REGION_WIDTH:  region_width = cfg_data;
          pdai_pkg::REG_REGION_HEIGHT: region_height = cfg_data;
          default: ;
        endcase
      end
      if (cand_valid && !cand_stall) begin
        want = judge_cand(cand.cand_x, cand.cand_y);
        due_verdicts.insert(due_verdicts.size(), want);
        tally[want.status]++;
      end
      if (done && !done_seen) begin
        done_seen = 1'b1;
        if (due_verdicts.size() != 0)
          report_err($sformatf("%0d results never arrived", due_verdicts.size()));
      end
    end
    fail_count <= errors;
    pending <= due_verdicts.size();
    n_accept <= tally[pdai_pkg::ST_ACCEPT];
    n_outside <= tally[pdai_pkg::ST_OUTSIDE];
    n_close <= tally[pdai_pkg::ST_CLOSE];
    n_full <= tally[pdai_pkg::ST_FULL];
  end

endmodule

@@ tb/sv/poisson_disc_accept_insert_tb.sv @@
// top of the poisson disc accept/insert testbench: clock, reset, register writes and
// candidate stimulus under three idling mixes
// depends on pdai_pkg, poisson_disc_accept_insert and poisson_disc_accept_insert_chk
`timescale 1ns / 1ps

module poisson_disc_accept_insert_tb;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cand_valid = 1'b0;
  logic                         cand_stall;
  pdai_pkg::cand_t              cand = '0;
  logic                         res_valid;
  logic                         res_stall = 1'b0;
  pdai_pkg::res_t               res;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [pdai_pkg::CFG_AW-1:0]  cfg_index = '0;
  logic [pdai_pkg::COORD_W-1:0] cfg_data = '0;
  logic                         done = 1'b0;

  int fail_count, pending, n_accept, n_outside, n_close, n_full;
  int send_pct = 0;
  int recv_pct = 0;
  int cur_md = 362;
  int cur_rw = 16384;
  int cur_rh = 16384;
  int last_x = 0;
  int last_y = 0;
  int n_sent = 0;
  int n_settings = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  poisson_disc_accept_insert i_dut (
    .clk        (clk),
    .rst        (rst),
    .cand_valid (cand_valid),
    .cand_stall (cand_stall),
    .cand       (cand),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  poisson_disc_accept_insert_chk i_chk (
    .clk        (clk),
    .rst        (rst),
    .cand_valid (cand_valid),
    .cand_stall (cand_stall),
    .cand       (cand),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .done       (done),
    .fail_count (fail_count),
    .pending    (pending),
    .n_accept   (n_accept),
    .n_outside  (n_outside),
    .n_close    (n_close),
    .n_full     (n_full)
  );

  always @(posedge clk) begin
    res_stall <= ($urandom_range(0, 99) < recv_pct);
  end

  initial begin
    #(20_000_000);
    $display("FAILURE");
    $finish;
  end

  task automatic put_cand(input int x, input int y);
    while ($urandom_range(0, 99) < send_pct) begin
      cand_valid <= 1'b0;
      @(posedge clk);
    end
    cand_valid <= 1'b1;
    cand.cand_x <= x[pdai_pkg::COORD_W-1:0];
    cand.cand_y <= y[pdai_pkg::COORD_W-1:0];
    @(posedge clk);
    while (cand_stall) @(posedge clk);
    n_sent++;
  endtask

  task automatic settle();
    cand_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input pdai_pkg::cfg_reg_t idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[pdai_pkg::COORD_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_settings(input int cs, input int md, input int rw, input int rh);
    write_reg(pdai_pkg::REG_CELL_SIZE, cs);
    write_reg(pdai_pkg::REG_MIN_DISTANCE, md);
    write_reg(pdai_pkg::REG_REGION_WIDTH, rw);
    write_reg(pdai_pkg::REG_REGION_HEIGHT, rh);
    cfg_valid <= 1'b0;
    cur_md = md;
    cur_rw = rw;
    cur_rh = rh;
    n_settings++;
  endtask

  function automatic int clip(input int v, input int hi);
    if (v < 0) return 0;
    if (v > hi - 1) return hi - 1;
    return v;
  endfunction

  // mostly in-region points, many near the previous one, plus outside and raw noise
  task automatic make_xy(output int x, output int y);
    int sel, r;
    sel = $urandom_range(0, 99);
    if (sel < 12) begin
      x = $urandom_range(0, 65535);
      y = $urandom_range(0, 65535);
    end else if (sel < 22) begin
      if ($urandom_range(0, 1)) begin
        x = $urandom_range(cur_rw, 65535);
        y = $urandom_range(0, 65535);
      end else begin
        x = $urandom_range(0, 65535);
        y = $urandom_range(cur_rh, 65535);
      end
    end else if (sel < 55) begin
      r = $urandom_range(0, 4 * cur_md);
      x = clip(last_x + r - 2 * cur_md, cur_rw);
      r = $urandom_range(0, 4 * cur_md);
      y = clip(last_y + r - 2 * cur_md, cur_rh);
    end else begin
      x = $urandom_range(0, cur_rw - 1);
      y = $urandom_range(0, cur_rh - 1);
    end
    if (sel >= 22) begin
      last_x = x;
      last_y = y;
    end
  endtask

  task automatic run_phase(input int s_pct, input int r_pct, input int n_items);
    int x, y, cs, md, rw, rh;
    send_pct = s_pct;
    recv_pct <= r_pct;
    for (int k = 0; k < 4; k++) begin
      case (k)
        0: load_settings(1, 1, 65535, 65535);
        1: load_settings(65535, 65535, 65535, 65535);
        default: begin
          md = $urandom_range(8, 2048);
          cs = (md * 181) >> 8;
          if ($urandom_range(0, 3) == 0) cs = $urandom_range(1, 65535);
          rw = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
                                           : $urandom_range(4096, 65535);
          rh = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
                                           : $urandom_range(4096, 65535);
          load_settings(cs, md, rw, rh);
        end
      endcase
      for (int j = 0; j < n_items / 4; j++) begin
        make_xy(x, y);
        put_cand(x, y);
        if ($urandom_range(0, 63) == 0) settle();
      end
      settle();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    send_pct = 28;
    recv_pct <= 83;

    // reset settings
    put_cand(0, 0);
    put_cand(0, 0);
    put_cand(16383, 16383);
    put_cand(16384, 0);
    put_cand(0, 16384);
    put_cand(65535, 65535);
    put_cand(362, 0);
    put_cand(0, 361);
    put_cand(8000, 8000);
    put_cand(8255, 8000);
    settle();

    // zero cell size, saturated grid, shared cells
    load_settings(0, 16, 65535, 65535);
    put_cand(1000, 1000);
    put_cand(1040, 1000);
    put_cand(1000, 1005);
    put_cand(1041, 1000);
    put_cand(65534, 65534);
    put_cand(0, 0);
    settle();

    // empty region
    load_settings(256, 362, 0, 100);
    put_cand(0, 0);
    put_cand(0, 50);
    settle();

    run_phase(28, 83, 440);
    run_phase(83, 28, 440);
    run_phase(0, 0, 440);

    done <= 1'b1;
    repeat (3) @(posedge clk);
    $display("ran %0d candidates under %0d register settings", n_sent, n_settings);
    $display("verdicts: %0d accepted, %0d outside, %0d too close, %0d store full",
             n_accept, n_outside, n_close, n_full);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ poisson_disc_accept_insert.f @@
+incdir+hdl
hdl/pdai_pkg.sv
hdl/pdai_div.sv
hdl/pdai_grid.sv
hdl/pdai_store.sv
hdl/poisson_disc_accept_insert.sv
tb/sv/poisson_disc_accept_insert_chk.sv
tb/sv/poisson_disc_accept_insert_tb.sv
